[rtl/core/sha_pkg.sv]
// SHA-256 stream hasher package: shared types, constants and round functions.
// Depends on nothing; used by every module of the hasher.
package sha_pkg;

    typedef enum logic [1:0] {
        t_CMD_BLOCK = 2'd0,
        t_CMD_PAD1  = 2'd1,
        t_CMD_PAD2  = 2'd2,
        t_CMD_FINAL = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd         cmd;
        logic [511:0] blk;
        logic         emit;
    } t_job;

    typedef enum logic [1:0] {
        t_BK_IDLE  = 2'd0,
        t_BK_ROUND = 2'd1,
        t_BK_ADD   = 2'd2,
        t_BK_OUT   = 2'd3
    } t_bk_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int unsigned LEN_POS = 56;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

[rtl/core/sha_stream_if.sv]
// Valid/ready stream interfaces for byte input and digest output.
// Depends on nothing.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/core/sha_front.sv]
// Front end: gathers bytes into 64-byte blocks, builds padding and length blocks.
// Depends on sha_pkg; feeds the job queue.
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_has_byte,
    input  logic              i_last,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output sha_pkg::t_job     o_job
);
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_count, n_count;
    logic         r_pend, n_pend;      // finishing pending after last
    logic         r_pend2, n_pend2;    // second padding block pending
    logic         r_jv, n_jv;
    sha_pkg::t_job r_job, n_job;
    logic [63:0]  w_bits;
    logic [511:0] w_pad;
    logic         w_two;

    assign o_job_valid = r_jv;
    assign o_job = r_job;
    assign o_ready = !r_pend && !r_pend2 && (!r_jv || i_job_ready);

    // Padded block from current fill; the length is left out when two blocks are needed.
    always_comb begin
        w_bits = {r_count, 3'b000};
        w_two = (r_fill >= 6'(sha_pkg::LEN_POS));
        w_pad = r_blk;
        for (int i = 0; i < 64; i++) begin
            if (i == int'(r_fill)) w_pad[511-8*i -: 8] = sha_pkg::PAD_BYTE;
            else if (i > int'(r_fill)) w_pad[511-8*i -: 8] = 8'h00;
        end
        if (!w_two) w_pad[63:0] = w_bits;
    end

    always_comb begin
        n_blk = r_blk;
        n_fill = r_fill;
        n_count = r_count;
        n_pend = r_pend;
        n_pend2 = r_pend2;
        n_jv = r_jv && !i_job_ready;
        n_job = r_job;
        if (!r_jv || i_job_ready) begin
            if (r_pend2) begin
                n_jv = 1'b1;
                n_job = '{cmd: sha_pkg::t_CMD_PAD2, blk: {448'd0, w_bits}, emit: 1'b1};
                n_pend2 = 1'b0;
                n_count = '0;
                n_fill = '0;
            end else if (r_pend) begin
                n_jv = 1'b1;
                n_job = '{cmd: sha_pkg::t_CMD_PAD1, blk: w_pad, emit: !w_two};
                n_pend = 1'b0;
                n_pend2 = w_two;
                if (!w_two) begin
                    n_count = '0;
                    n_fill = '0;
                end
            end else if (i_valid) begin
                if (i_has_byte) begin
                    n_blk[511-8*int'(r_fill) -: 8] = i_data_byte;
                    n_count = r_count + 61'd1;
                    n_fill = r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        n_jv = 1'b1;
                        n_job = '{cmd: sha_pkg::t_CMD_BLOCK, blk: n_blk, emit: 1'b0};
                        n_pend = i_last;
                    end else if (i_last) begin
                        n_pend = 1'b1;
                    end
                end else if (i_last) begin
                    n_pend = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_count <= '0;
            r_pend <= 1'b0;
            r_pend2 <= 1'b0;
            r_jv <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_count <= n_count;
            r_pend <= n_pend;
            r_pend2 <= n_pend2;
            r_jv <= n_jv;
        end
        r_blk <= n_blk;
        r_job <= n_job;
    end

`ifndef SYNTHESIS
    a_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pend && r_pend2)) else $error("both finish flags set");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend || r_pend2) |-> !o_ready) else $error("input taken while finishing");
    a_job_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_jv && !i_job_ready) |=> (r_jv && $stable(r_job))) else $error("job dropped");
`endif
endmodule

[rtl/core/sha_queue.sv]
// Two-entry job queue between front end and compression engine.
// Depends on sha_pkg.
module sha_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output sha_pkg::t_job o_job
);
    sha_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("queue pointers");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1 && w_pop && !w_push) |=> !o_valid) else $error("queue empty");
`endif
endmodule

[rtl/core/sha_engine.sv]
// Compression engine: one SHA-256 round per cycle, chaining state, digest output.
// Depends on sha_pkg.
module sha_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_digest_word,
    output logic [2:0]    o_word_index,
    output logic          o_last_word
);
    sha_pkg::t_bk_state r_st, n_st;
    logic [255:0] r_h;
    logic [255:0] r_v;
    logic [511:0] r_w;
    logic [5:0]   r_rnd;
    logic         r_emit;
    logic [2:0]   r_idx;
    logic [31:0]  w_new, w_s0, w_s1, w_t1, w_t2, w_ch, w_maj, w_b0, w_b1;
    logic [31:0]  a, b, c, d, e, f, g, h;
    logic [255:0] w_sum;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_v;
        w_s0 = sha_pkg::rotr(r_w[479:448], 7) ^ sha_pkg::rotr(r_w[479:448], 18)
             ^ (r_w[479:448] >> 3);
        w_s1 = sha_pkg::rotr(r_w[63:32], 17) ^ sha_pkg::rotr(r_w[63:32], 19)
             ^ (r_w[63:32] >> 10);
        w_new = w_s1 + r_w[223:192] + w_s0 + r_w[511:480];
        w_b1 = sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25);
        w_ch = (e & f) ^ (~e & g);
        w_t1 = h + w_b1 + w_ch + sha_pkg::round_k(r_rnd) + r_w[511:480];
        w_b0 = sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22);
        w_maj = (a & b) ^ (a & c) ^ (b & c);
        w_t2 = w_b0 + w_maj;
        for (int i = 0; i < 8; i++)
            w_sum[255-32*i -: 32] = r_h[255-32*i -: 32] + r_v[255-32*i -: 32];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            sha_pkg::t_BK_IDLE:  if (i_valid) n_st = sha_pkg::t_BK_ROUND;
            sha_pkg::t_BK_ROUND: if (r_rnd == 6'd63) n_st = sha_pkg::t_BK_ADD;
            sha_pkg::t_BK_ADD:   n_st = r_emit ? sha_pkg::t_BK_OUT : sha_pkg::t_BK_IDLE;
            sha_pkg::t_BK_OUT:   if (i_ready && r_idx == 3'd7) n_st = sha_pkg::t_BK_IDLE;
            default:             n_st = sha_pkg::t_BK_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_st == sha_pkg::t_BK_IDLE);
        o_valid = (r_st == sha_pkg::t_BK_OUT);
        o_digest_word = r_h[255-32*int'(r_idx) -: 32];
        o_word_index = r_idx;
        o_last_word = (r_idx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= sha_pkg::t_BK_IDLE;
            r_h <= sha_pkg::INIT_HASH;
            r_idx <= '0;
            r_rnd <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                sha_pkg::t_BK_IDLE: begin
                    r_rnd <= '0;
                    r_idx <= '0;
                end
                sha_pkg::t_BK_ROUND: r_rnd <= r_rnd + 6'd1;
                sha_pkg::t_BK_ADD: r_h <= w_sum;
                sha_pkg::t_BK_OUT: if (i_ready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) r_h <= sha_pkg::INIT_HASH;
                end
                default: ;
            endcase
        end
        if (r_st == sha_pkg::t_BK_IDLE) begin
            r_w <= i_job.blk;
            r_v <= r_h;
            r_emit <= i_job.emit;
        end else if (r_st == sha_pkg::t_BK_ROUND) begin
            r_w <= {r_w[479:0], w_new};
            r_v <= {w_t1 + w_t2, a, b, c, d + w_t1, e, f, g};
        end
    end

`ifndef SYNTHESIS
    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_idx))) else $error("digest word lost");
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == sha_pkg::t_BK_ROUND && r_rnd == 6'd63) |=> r_st == sha_pkg::t_BK_ADD)
        else $error("round count");
    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (r_h == sha_pkg::INIT_HASH))
        else $error("chain not reset");
`endif
endmodule

[rtl/core/sha256_stream_hasher.sv]
// SHA-256 stream hasher top level: front end, job queue, compression engine.
// Bytes are taken one per cycle unless a finish is pending or a job waits on the queue;
// each 64-byte block takes one load, 64 rounds and one add in the engine, which loads no
// new block until it is idle again; the front end gathers bytes meanwhile. After last, the
// padding and queued blocks go through, then digest words, one per cycle while ready.
// Synchronous active-low reset loads the initial hash and empties the queue.
module sha256_stream_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    logic          w_fj_valid, w_fj_ready, w_qe_valid, w_qe_ready;
    sha_pkg::t_job w_fj, w_qe;

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in.valid), .o_ready(i_in.ready),
        .i_data_byte(i_in.data_byte), .i_has_byte(i_in.has_byte), .i_last(i_in.last),
        .o_job_valid(w_fj_valid), .i_job_ready(w_fj_ready), .o_job(w_fj)
    );

    sha_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fj_valid), .o_ready(w_fj_ready), .i_job(w_fj),
        .o_valid(w_qe_valid), .i_ready(w_qe_ready), .o_job(w_qe)
    );

    sha_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qe_valid), .o_ready(w_qe_ready), .i_job(w_qe),
        .o_valid(o_out.valid), .i_ready(o_out.ready),
        .o_digest_word(o_out.digest_word), .o_word_index(o_out.word_index),
        .o_last_word(o_out.last_word)
    );
endmodule
